// File: rtl/core/agc_pkg.sv
// Shared constants and types for the white-balance gain calculator.
`default_nettype none
package agc_pkg;
    localparam int RATIO_W = 16;
    localparam int FRAC_W = 8;
    localparam logic [RATIO_W-1:0] UNITY_GAIN = 16'h0100;
    localparam logic [RATIO_W-1:0] RESET_TYP_RG = 16'd547;
    localparam logic [RATIO_W-1:0] RESET_TYP_BG = 16'd612;
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_TYP_RG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYP_BG = 8'd1;

    typedef struct packed {
        logic [RATIO_W-1:0] red;
        logic               r_lt;
        logic               b_lt;
        logic               err;
    } t_front;

    typedef struct packed {
        logic [RATIO_W-1:0] gg;
        logic               red_pin;
        logic               blue_pin;
        logic               err;
    } t_mid;
endpackage
`default_nettype wire

// File: rtl/core/agc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module agc_div #(
    parameter int N  = 24,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [N-1:0]  i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [N-1:0]       o_quot,
    output logic [DW-1:0]      o_divisor,
    output logic [SW-1:0]      o_side
);
    logic [DW-1:0] r_rem [N];
    logic [N-1:0]  r_dq  [N];
    logic [DW-1:0] r_d   [N];
    logic [SW-1:0] r_side[N];
    logic          r_v   [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [N-1:0]  dq_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] side_in;
        logic          v_in;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign dq_in   = i_dividend;
            assign d_in    = i_divisor;
            assign side_in = i_side;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign dq_in   = r_dq[k-1];
            assign d_in    = r_d[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_v[k-1];
        end
        assign t    = {rem_in, dq_in[N-1]};
        assign diff = t - {1'b0, d_in};
        assign ge   = (t >= {1'b0, d_in});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
                r_dq[k]   <= {dq_in[N-2:0], ge};
                r_d[k]    <= d_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid   = r_v[N-1];
    assign o_quot    = r_dq[N-1];
    assign o_divisor = r_d[N-1];
    assign o_side    = r_side[N-1];
endmodule
`default_nettype wire

// File: rtl/core/agc_sel.sv
// Green gain selection, channel pinning and scaling products.
`default_nettype none
module agc_sel (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [agc_pkg::RATIO_W-1:0]   i_g_from_r,
    input  wire logic [agc_pkg::RATIO_W-1:0]   i_g_from_b,
    input  wire logic                          i_r_lt,
    input  wire logic                          i_b_lt,
    input  wire logic                          i_err,
    input  wire logic [agc_pkg::RATIO_W-1:0]   i_trg,
    input  wire logic [agc_pkg::RATIO_W-1:0]   i_tbg,
    output logic                               o_valid,
    output logic [2*agc_pkg::RATIO_W-1:0]      o_prod_r,
    output logic [2*agc_pkg::RATIO_W-1:0]      o_prod_b,
    output agc_pkg::t_mid                      o_mid
);
    agc_pkg::t_mid n_mid;
    logic          r_valid;
    logic [2*agc_pkg::RATIO_W-1:0] r_prod_r, r_prod_b;
    agc_pkg::t_mid r_mid;

    always_comb begin
        n_mid.err      = i_err;
        n_mid.red_pin  = 1'b0;
        n_mid.blue_pin = 1'b0;
        n_mid.gg       = agc_pkg::UNITY_GAIN;
        case ({i_b_lt, i_r_lt})
            2'b11: begin
                n_mid.gg = agc_pkg::UNITY_GAIN;
            end
            2'b10: begin
                n_mid.red_pin = 1'b1;
                n_mid.gg      = i_g_from_r;
            end
            2'b01: begin
                n_mid.blue_pin = 1'b1;
                n_mid.gg       = i_g_from_b;
            end
            default: begin
                if (i_g_from_b > i_g_from_r) begin
                    n_mid.blue_pin = 1'b1;
                    n_mid.gg       = i_g_from_b;
                end else begin
                    n_mid.red_pin = 1'b1;
                    n_mid.gg      = i_g_from_r;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid    <= n_mid;
            r_prod_r <= n_mid.gg * i_trg;
            r_prod_b <= n_mid.gg * i_tbg;
        end
    end

    assign o_valid  = r_valid;
    assign o_prod_r = r_prod_r;
    assign o_prod_b = r_prod_b;
    assign o_mid    = r_mid;
endmodule
`default_nettype wire

// File: rtl/core/awb_otp_gain_calc.sv
// White-balance gain calculator: top level with registers and pipeline.
// Accepts one ratio set per cycle unless the output stalls, and returns red,
// green and blue gains (0x100 is unity) through 24 divider stages for the
// green candidates, one select and multiply stage, 32 divider stages for the
// red and blue gains and one output register. The whole pipeline halts while
// a result waits at the output. A zero ratio or typical value sets ratio_error
// and zeroes the gains. Typical ratios are written at index 0 (R/G) and 1 (B/G).
`default_nettype none
module awb_otp_gain_calc (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [agc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [agc_pkg::RATIO_W-1:0]     i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [agc_pkg::RATIO_W-1:0]     i_red_ratio,
    input  wire logic [agc_pkg::RATIO_W-1:0]     i_blue_ratio,
    input  wire logic [agc_pkg::RATIO_W-1:0]     i_greenb_ratio,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [agc_pkg::RATIO_W-1:0]          o_red_gain,
    output logic [agc_pkg::RATIO_W-1:0]          o_green_gain,
    output logic [agc_pkg::RATIO_W-1:0]          o_blue_gain,
    output logic                                 o_ratio_error
);
    localparam int RW = agc_pkg::RATIO_W;
    localparam int AW = RW + agc_pkg::FRAC_W;
    localparam int BW = 2 * RW;
    localparam int FW = $bits(agc_pkg::t_front);
    localparam int MW = $bits(agc_pkg::t_mid);

    logic [RW-1:0] r_trg, r_tbg;
    logic          en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trg <= agc_pkg::RESET_TYP_RG;
            r_tbg <= agc_pkg::RESET_TYP_BG;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                agc_pkg::REG_TYP_RG: r_trg <= i_cfg_data;
                agc_pkg::REG_TYP_BG: r_tbg <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    logic r_out_valid;
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    agc_pkg::t_front front_in, front_a;
    assign front_in.red  = i_red_ratio;
    assign front_in.r_lt = i_red_ratio < r_trg;
    assign front_in.b_lt = i_blue_ratio < r_tbg;
    assign front_in.err  = (i_red_ratio == '0) || (i_blue_ratio == '0)
                        || (i_greenb_ratio == '0) || (r_trg == '0) || (r_tbg == '0);

    logic          va1, va2;
    logic [AW-1:0] qa1, qa2;
    logic [RW-1:0] da1, da2;
    logic [FW-1:0] sa1;
    logic [RW-1:0] sa2;

    agc_div #(.N(AW), .DW(RW), .SW(FW)) u_div_gr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_in_valid && en),
        .i_dividend({i_red_ratio, {agc_pkg::FRAC_W{1'b0}}}),
        .i_divisor(r_trg), .i_side(front_in),
        .o_valid(va1), .o_quot(qa1), .o_divisor(da1), .o_side(sa1)
    );
    agc_div #(.N(AW), .DW(RW), .SW(RW)) u_div_gb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(i_in_valid && en),
        .i_dividend({i_blue_ratio, {agc_pkg::FRAC_W{1'b0}}}),
        .i_divisor(r_tbg), .i_side(i_blue_ratio),
        .o_valid(va2), .o_quot(qa2), .o_divisor(da2), .o_side(sa2)
    );
    assign front_a = agc_pkg::t_front'(sa1);

    logic            vm;
    logic [BW-1:0]   prod_r, prod_b;
    agc_pkg::t_mid   mid;
    logic [RW-1:0]   r_red_m, r_blue_m;

    agc_sel u_sel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(va1 && va2),
        .i_g_from_r(qa1[RW-1:0]), .i_g_from_b(qa2[RW-1:0]),
        .i_r_lt(front_a.r_lt), .i_b_lt(front_a.b_lt), .i_err(front_a.err),
        .i_trg(da1), .i_tbg(da2),
        .o_valid(vm), .o_prod_r(prod_r), .o_prod_b(prod_b), .o_mid(mid)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red_m  <= front_a.red;
            r_blue_m <= sa2;
        end
    end

    logic          vb1, vb2;
    logic [BW-1:0] qb1, qb2;
    logic [RW-1:0] db1, db2;
    logic [MW-1:0] sb1;
    logic          sb2;
    agc_pkg::t_mid mid_b;

    agc_div #(.N(BW), .DW(RW), .SW(MW)) u_div_red (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(vm),
        .i_dividend(prod_r), .i_divisor(r_red_m), .i_side(mid),
        .o_valid(vb1), .o_quot(qb1), .o_divisor(db1), .o_side(sb1)
    );
    agc_div #(.N(BW), .DW(RW), .SW(1)) u_div_blue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(vm),
        .i_dividend(prod_b), .i_divisor(r_blue_m), .i_side(mid.err),
        .o_valid(vb2), .o_quot(qb2), .o_divisor(db2), .o_side(sb2)
    );
    assign mid_b = agc_pkg::t_mid'(sb1);

    logic [RW-1:0] r_red_gain, r_green_gain, r_blue_gain;
    logic          r_err;
    logic          zero_div;
    assign zero_div = (db1 == '0) || (db2 == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vb1 && vb2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (sb2 || zero_div) begin
                r_err        <= 1'b1;
                r_red_gain   <= '0;
                r_green_gain <= '0;
                r_blue_gain  <= '0;
            end else begin
                r_err        <= mid_b.err;
                r_red_gain   <= mid_b.red_pin ? agc_pkg::UNITY_GAIN : qb1[RW-1:0];
                r_green_gain <= mid_b.gg;
                r_blue_gain  <= mid_b.blue_pin ? agc_pkg::UNITY_GAIN : qb2[RW-1:0];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red_gain    = r_red_gain;
    assign o_green_gain  = r_green_gain;
    assign o_blue_gain   = r_blue_gain;
    assign o_ratio_error = r_err;
endmodule
`default_nettype wire
